FILE: sv/sfd_pkg.sv
// ---------------------------------------------------------------------------
// sfd_pkg: shared constants and types of the serial frame decoder
// Frame layout, channel scaling constants and the controller/datapath links.
// ---------------------------------------------------------------------------
package sfd_pkg;

    // frame layout
    localparam int unsigned NUM_CHANNELS = 16;
    localparam int unsigned FULL_SCALE   = 1024;
    localparam int unsigned CHAN_BITS    = 11;
    localparam int unsigned DATA_BYTES   = 22;
    localparam int unsigned DATA_BITS    = DATA_BYTES * 8;
    localparam int unsigned FRAME_LEN    = 25;

    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE   = 8'h00;

    // byte position codes inside a frame
    localparam logic [4:0] POS_FIRST = 5'd1;
    localparam logic [4:0] POS_FLAGS = 5'(DATA_BYTES + 1);
    localparam logic [4:0] POS_LAST  = 5'(FRAME_LEN - 1);

    // flag byte bits
    localparam int unsigned FLAG_LOST     = 2;
    localparam int unsigned FLAG_FAILSAFE = 3;
    localparam int unsigned FLAG_MARK     = 4;
    localparam int unsigned FLAG_CH01     = 5;
    localparam int unsigned FLAG_CH23     = 6;
    localparam int unsigned FLAG_HIRES    = 7;

    localparam logic [15:0] MASK_PLAIN  = 16'hffff;
    localparam logic [15:0] MASK_MARKED = 16'hfff0;
    localparam logic [15:0] MASK_CH01   = 16'h0003;
    localparam logic [15:0] MASK_CH23   = 16'h000c;

    localparam logic [11:0] CHAN_CENTER = 12'h3E0;

    // controller to datapath
    typedef struct packed {
        logic store_data;
        logic store_flags;
        logic shift_chan;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_start;
        logic frame_ok;
    } t_dp_status;

endpackage

FILE: sv/sfd_byte_if.sv
// ---------------------------------------------------------------------------
// sfd_byte_if: received byte channel
// Valid/ready channel carrying one serial byte per word.
// ---------------------------------------------------------------------------
interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/sfd_chan_if.sv
// ---------------------------------------------------------------------------
// sfd_chan_if: channel result channel
// Valid/ready channel carrying one decoded channel per word.
// ---------------------------------------------------------------------------
interface sfd_chan_if;
    logic               valid;
    logic               ready;
    logic [3:0]         channel_index;
    logic signed [11:0] channel_value;
    logic               last_channel;
    logic [15:0]        active_mask;
    logic               high_resolution;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, output active_mask,
                    output high_resolution, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input last_channel, input active_mask,
                    input high_resolution, output ready);
endinterface

FILE: sv/sfd_ctrl.sv
// ---------------------------------------------------------------------------
// sfd_ctrl: frame decoder controller
// Hunts for the start byte, counts frame bytes and sequences channel output.
// ---------------------------------------------------------------------------
module sfd_ctrl #(
    parameter int unsigned NUM_CHANNELS = sfd_pkg::NUM_CHANNELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [3:0]          o_chan,
    output logic                o_last,
    input  sfd_pkg::t_dp_status i_status,
    output sfd_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] ST_HUNT    = 2'd0;
    localparam logic [1:0] ST_COLLECT = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    localparam logic [3:0] LAST_CHAN = 4'(NUM_CHANNELS - 1);

    logic [1:0] r_state, n_state;
    logic [4:0] r_pos, n_pos;
    logic [3:0] r_chan, n_chan;
    logic       r_enable;

    logic in_take;
    logic out_take;

    assign o_in_ready  = (r_state != ST_EMIT);
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_chan      = r_chan;
    assign o_last      = (r_chan == LAST_CHAN);

    // bytes are taken whenever ready, but only counted while enabled
    assign in_take  = i_in_valid && o_in_ready && r_enable;
    assign out_take = o_out_valid && i_out_ready;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_chan  = r_chan;
        o_cmd   = '0;
        case (r_state)
            ST_HUNT: begin
                if (in_take && i_status.is_start) begin
                    n_state = ST_COLLECT;
                    n_pos   = sfd_pkg::POS_FIRST;
                end
            end
            ST_COLLECT: begin
                if (in_take) begin
                    if (r_pos == sfd_pkg::POS_LAST) begin
                        n_pos  = '0;
                        n_chan = '0;
                        n_state = i_status.frame_ok ? ST_EMIT : ST_HUNT;
                    end else begin
                        o_cmd.store_data  = (r_pos != sfd_pkg::POS_FLAGS);
                        o_cmd.store_flags = (r_pos == sfd_pkg::POS_FLAGS);
                        n_pos = r_pos + 5'd1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_take) begin
                    o_cmd.shift_chan = 1'b1;
                    if (o_last) begin
                        n_state = ST_HUNT;
                    end else begin
                        n_chan = r_chan + 4'd1;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HUNT;
            r_pos    <= '0;
            r_chan   <= '0;
            r_enable <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_chan  <= n_chan;
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
        end
    end

endmodule

FILE: sv/sfd_datapath.sv
// ---------------------------------------------------------------------------
// sfd_datapath: frame decoder datapath
// Frame shift register, flag checks and per-channel scaling.
// ---------------------------------------------------------------------------
module sfd_datapath #(
    parameter int unsigned FULL_SCALE = sfd_pkg::FULL_SCALE
) (
    input  logic                i_clk,
    input  logic [7:0]          i_rx_byte,
    input  sfd_pkg::t_dp_cmd    i_cmd,
    output sfd_pkg::t_dp_status o_status,
    output logic signed [11:0]  o_value,
    output logic [15:0]         o_mask,
    output logic                o_hires
);

    logic [sfd_pkg::DATA_BITS-1:0] r_bits;
    logic [7:0]                    r_flags;

    logic [10:0]        raw;
    logic signed [11:0] delta;
    logic signed [14:0] p5;
    logic signed [14:0] p5_adj;
    logic signed [11:0] norm_val;
    logic [10:0]        mag;
    logic [13:0]        m5;
    logic [12:0]        rmag;
    logic [12:0]        cmag;
    logic signed [13:0] hval;

    // data bytes shift in from the top, so byte 1 ends at the bottom;
    // each delivered channel shifts the next one down
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_data) begin
            r_bits <= {i_rx_byte, r_bits[sfd_pkg::DATA_BITS-1:8]};
        end else if (i_cmd.shift_chan) begin
            r_bits <= {{sfd_pkg::CHAN_BITS{1'b0}},
                       r_bits[sfd_pkg::DATA_BITS-1:sfd_pkg::CHAN_BITS]};
        end
        if (i_cmd.store_flags) begin
            r_flags <= i_rx_byte;
        end
    end

    // frame checks
    assign o_status.is_start = (i_rx_byte == sfd_pkg::START_BYTE);
    assign o_status.frame_ok = (i_rx_byte == sfd_pkg::END_BYTE)
                               && !r_flags[sfd_pkg::FLAG_LOST]
                               && !r_flags[sfd_pkg::FLAG_FAILSAFE];

    // mask and resolution from flags
    always_comb begin
        o_mask = sfd_pkg::MASK_PLAIN;
        if (r_flags[sfd_pkg::FLAG_MARK]) begin
            o_mask = sfd_pkg::MASK_MARKED;
            if (r_flags[sfd_pkg::FLAG_CH01]) o_mask = o_mask | sfd_pkg::MASK_CH01;
            if (r_flags[sfd_pkg::FLAG_CH23]) o_mask = o_mask | sfd_pkg::MASK_CH23;
        end
    end
    assign o_hires = r_flags[sfd_pkg::FLAG_MARK] && r_flags[sfd_pkg::FLAG_HIRES];

    // centered channel value
    assign raw   = r_bits[sfd_pkg::CHAN_BITS-1:0];
    assign delta = $signed({1'b0, raw}) - $signed(sfd_pkg::CHAN_CENTER);

    // plain scale: 5/8, truncated toward zero
    assign p5       = ($signed({{3{delta[11]}}, delta}) <<< 2)
                      + $signed({{3{delta[11]}}, delta});
    assign p5_adj   = p5[14] ? (p5 + 15'sd7) : p5;
    assign norm_val = 12'(p5_adj >>> 3);

    // high resolution: 5/4 on the magnitude, half away from zero, clamped
    assign mag  = delta[11] ? 11'(-delta) : delta[10:0];
    assign m5   = ({3'b0, mag} << 2) + {3'b0, mag} + 14'd2;
    assign rmag = {1'b0, m5[13:2]};
    assign cmag = (rmag > 13'(FULL_SCALE)) ? 13'(FULL_SCALE) : rmag;
    assign hval = delta[11] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});

    assign o_value = o_hires ? 12'(hval) : norm_val;

endmodule

FILE: sv/sbus_frame_decoder.sv
// ---------------------------------------------------------------------------
// sbus_frame_decoder: 16-channel serial frame decoder
// Collects 25-byte frames from a byte stream and emits scaled channels.
// ---------------------------------------------------------------------------
// While enabled, each received byte word is taken; outside a
// frame only the start byte 0x0F is kept. Bytes are always taken (ready is
// high) except while a frame's channels are being delivered; with enable
// low they are taken and dropped. On the 25th byte the end byte and the
// failsafe and frame-lost flags are checked, and a good frame then yields
// 16 channel words, one per cycle that the sink takes one, walked out of
// the 176-bit frame shift register; the input stalls for those 16 words.
module sbus_frame_decoder #(
    parameter int unsigned NUM_CHANNELS = sfd_pkg::NUM_CHANNELS,
    parameter int unsigned FULL_SCALE   = sfd_pkg::FULL_SCALE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    sfd_byte_if.sink   i_rx,
    sfd_chan_if.source o_res
);

    sfd_pkg::t_dp_cmd    cmd;
    sfd_pkg::t_dp_status status;

    sfd_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_rx.valid),
        .o_in_ready    (i_rx.ready),
        .o_out_valid   (o_res.valid),
        .i_out_ready   (o_res.ready),
        .o_chan        (o_res.channel_index),
        .o_last        (o_res.last_channel),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    sfd_datapath #(
        .FULL_SCALE (FULL_SCALE)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rx_byte (i_rx.rx_byte),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_value   (o_res.channel_value),
        .o_mask    (o_res.active_mask),
        .o_hires   (o_res.high_resolution)
    );

    // input is held off while channels are delivered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_rx.ready)
        else $error("input ready while channel words pending");

    // a frame's output starts at channel zero
    a_first_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> (o_res.channel_index == 4'd0))
        else $error("frame output did not start at channel zero");

    // the last channel word closes the frame
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.last_channel) |=> !o_res.valid)
        else $error("channel words continue after last channel");

    // scaled value stays within full scale
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((int'(o_res.channel_value) >= -int'(FULL_SCALE))
                         && (int'(o_res.channel_value) <= int'(FULL_SCALE))))
        else $error("channel value outside full scale");

endmodule
